/* sv/lowest_common_ancestor_lifting_macros.svh */
// assertion macros shared by the lowest common ancestor lifting block
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH

// same-cycle implication check
`define LCAL_ASSERT_IMP(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("lcal same-cycle check failed");

// next-cycle implication check
`define LCAL_ASSERT_NXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("lcal next-cycle check failed");

`endif

/* sv/lcal_pkg.sv */
// types, codes and constants of the lowest common ancestor lifting block
`timescale 1ns / 1ps

package lcal_pkg;

  localparam int NODE_W      = 10;
  localparam int DEPTH_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int LEVEL_IDX_W = 4;
  localparam int CMP_W       = 17;
  localparam int NODE_SPAN   = 1024;
  localparam int NODES_DEF   = 1024;
  localparam int LEVELS_DEF  = 10;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_NO_BUILD = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [DEPTH_W-1:0] node_depth;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [1:0]        status;
  } result_t;

  // memory requests from the sequencer to the stores
  typedef struct packed {
    logic [LEVEL_IDX_W-1:0] jt_rd_lvl;
    logic [NODE_W-1:0]      jt_rd_node;
    logic                   jt_we;
    logic [LEVEL_IDX_W-1:0] jt_wr_lvl;
    logic [NODE_W-1:0]      jt_wr_node;
    logic [NODE_W-1:0]      jt_wr_data;
    logic [NODE_W-1:0]      dp_rd_node;
    logic                   dp_we;
    logic [NODE_W-1:0]      dp_wr_node;
    logic [DEPTH_W-1:0]     dp_wr_data;
  } mem_req_t;

endpackage

/* sv/lcal_store.sv */
// jump table and depth memories with registered read data
`timescale 1ns / 1ps

module lcal_store #(
  parameter int NODES  = lcal_pkg::NODES_DEF,
  parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  lcal_pkg::mem_req_t          req,
  output logic [lcal_pkg::NODE_W-1:0]  jt_rd_data,
  output logic [lcal_pkg::DEPTH_W-1:0] dp_rd_data
);

  localparam int DEPTH = (NODES < lcal_pkg::NODE_SPAN) ? NODES : lcal_pkg::NODE_SPAN;
  localparam int NW    = $clog2(DEPTH);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [lcal_pkg::NODE_W-1:0]  jt_mem [LEVELS][DEPTH];
  logic [lcal_pkg::DEPTH_W-1:0] dp_mem [DEPTH];

  logic jt_same;

  // a build writes and reads the same entry when only one node is in use
  assign jt_same = req.jt_we && (req.jt_wr_lvl == req.jt_rd_lvl) &&
                   (req.jt_wr_node == req.jt_rd_node);

  // jump table, write-first
  always_ff @(posedge clk) begin
    if (req.jt_we) begin
      jt_mem[LW'(req.jt_wr_lvl)][NW'(req.jt_wr_node)] <= req.jt_wr_data;
    end
    if (jt_same) begin
      jt_rd_data <= req.jt_wr_data;
    end else begin
      jt_rd_data <= jt_mem[LW'(req.jt_rd_lvl)][NW'(req.jt_rd_node)];
    end
  end

  // depth store
  always_ff @(posedge clk) begin
    if (req.dp_we) begin
      dp_mem[NW'(req.dp_wr_node)] <= req.dp_wr_data;
    end
    dp_rd_data <= dp_mem[NW'(req.dp_rd_node)];
  end

endmodule

/* sv/lcal_cmp.sv */
// shared compare unit: lhs against rhs plus an optional power of two
`timescale 1ns / 1ps

module lcal_cmp (
  input  logic [lcal_pkg::CMP_W-1:0]       lhs,
  input  logic [lcal_pkg::CMP_W-1:0]       rhs,
  input  logic                             add_en,
  input  logic [lcal_pkg::LEVEL_IDX_W-1:0] shift,
  output logic                             ge,
  output logic                             eq
);

  logic [lcal_pkg::CMP_W-1:0] rhs_sum;

  // offset add then magnitude and equality compare
  assign rhs_sum = rhs + (add_en ? (lcal_pkg::CMP_W'(1) << shift) : '0);
  assign ge      = (lhs >= rhs_sum);
  assign eq      = (lhs == rhs_sum);

endmodule

/* sv/lcal_ctrl.sv */
// sequencer for load, build and query items around the shared compare unit
`timescale 1ns / 1ps
`include "lowest_common_ancestor_lifting_macros.svh"

module lcal_ctrl #(
  parameter int NODES  = lcal_pkg::NODES_DEF,
  parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lcal_pkg::cmd_t               cmd,
  input  logic                         cfg_we,
  input  logic [lcal_pkg::COUNT_W-1:0] cfg_data,
  output logic                         busy,
  output logic                         done,
  output lcal_pkg::result_t            result,
  output lcal_pkg::mem_req_t           req,
  input  logic [lcal_pkg::NODE_W-1:0]  jt_rd_data,
  input  logic [lcal_pkg::DEPTH_W-1:0] dp_rd_data
);

  localparam int NODE_LIM = (NODES < lcal_pkg::NODE_SPAN) ? NODES : lcal_pkg::NODE_SPAN;
  localparam int NDW = lcal_pkg::NODE_W;
  localparam int KW  = lcal_pkg::LEVEL_IDX_W;
  localparam int CW  = lcal_pkg::COUNT_W;

  localparam logic [KW-1:0] LAST_LVL = KW'(LEVELS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QDA  = 4'd1;
  localparam logic [3:0] S_QDB  = 4'd2;
  localparam logic [3:0] S_LCMP = 4'd3;
  localparam logic [3:0] S_LJU  = 4'd4;
  localparam logic [3:0] S_LDU  = 4'd5;
  localparam logic [3:0] S_PRU  = 4'd6;
  localparam logic [3:0] S_PRV  = 4'd7;
  localparam logic [3:0] S_PCMP = 4'd8;
  localparam logic [3:0] S_FCHK = 4'd9;
  localparam logic [3:0] S_FRD  = 4'd10;
  localparam logic [3:0] S_BX   = 4'd11;
  localparam logic [3:0] S_BY   = 4'd12;

  logic [3:0]                     state, state_next;
  logic [KW-1:0]                  k, k_next;
  logic [NDW-1:0]                 i, i_next;
  logic [NDW-1:0]                 u, u_next;
  logic [NDW-1:0]                 v, v_next;
  logic [NDW-1:0]                 pu, pu_next;
  logic [lcal_pkg::DEPTH_W-1:0]   du, du_next;
  logic [lcal_pkg::DEPTH_W-1:0]   dv, dv_next;
  logic [CW-1:0]                  node_count;
  logic                           table_built, table_built_next;
  logic                           done_next;
  lcal_pkg::result_t              result_next;

  logic [CW-1:0]                  n_eff;
  logic                           range_bad;
  logic [lcal_pkg::CMP_W-1:0]     cmp_lhs, cmp_rhs;
  logic                           cmp_add;
  logic                           cmp_ge, cmp_eq;

  // node count in use, capped by the store size
  assign n_eff = (node_count < CW'(NODE_LIM)) ? node_count : CW'(NODE_LIM);
  assign range_bad = ({1'b0, cmd.node_a} >= n_eff) || ({1'b0, cmd.node_b} >= n_eff);
  assign busy = (state != S_IDLE);

  lcal_cmp u_cmp (
    .lhs    (cmp_lhs),
    .rhs    (cmp_rhs),
    .add_en (cmp_add),
    .shift  (k),
    .ge     (cmp_ge),
    .eq     (cmp_eq)
  );

  // next-state and memory request logic
  always_comb begin
    state_next       = state;
    k_next           = k;
    i_next           = i;
    u_next           = u;
    v_next           = v;
    pu_next          = pu;
    du_next          = du;
    dv_next          = dv;
    table_built_next = table_built;
    done_next        = 1'b0;
    result_next      = result;
    req              = '0;
    cmp_lhs          = '0;
    cmp_rhs          = '0;
    cmp_add          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            lcal_pkg::KIND_LOAD: begin
              done_next          = 1'b1;
              result_next.ancestor = '0;
              if (range_bad) begin
                result_next.status = lcal_pkg::STATUS_RANGE;
              end else begin
                result_next.status = lcal_pkg::STATUS_OK;
                req.jt_we          = 1'b1;
                req.jt_wr_lvl      = '0;
                req.jt_wr_node     = cmd.node_a;
                req.jt_wr_data     = cmd.node_b;
                req.dp_we          = 1'b1;
                req.dp_wr_node     = cmd.node_a;
                req.dp_wr_data     = cmd.node_depth;
                table_built_next   = 1'b0;
              end
            end
            lcal_pkg::KIND_BUILD: begin
              if ((n_eff == '0) || (LEVELS == 1)) begin
                done_next          = 1'b1;
                result_next.ancestor = '0;
                result_next.status = lcal_pkg::STATUS_OK;
                table_built_next   = 1'b1;
              end else begin
                k_next         = KW'(1);
                i_next         = '0;
                req.jt_rd_lvl  = '0;
                req.jt_rd_node = '0;
                state_next     = S_BX;
              end
            end
            lcal_pkg::KIND_QUERY: begin
              result_next.ancestor = '0;
              if (range_bad) begin
                done_next          = 1'b1;
                result_next.status = lcal_pkg::STATUS_RANGE;
              end else if (!table_built) begin
                done_next          = 1'b1;
                result_next.status = lcal_pkg::STATUS_NO_BUILD;
              end else begin
                req.dp_rd_node = cmd.node_a;
                u_next         = cmd.node_a;
                v_next         = cmd.node_b;
                state_next     = S_QDA;
              end
            end
            default: begin
              done_next          = 1'b1;
              result_next.ancestor = '0;
              result_next.status = lcal_pkg::STATUS_OK;
            end
          endcase
        end
      end

      // depth of the first node arrives, fetch the second
      S_QDA: begin
        du_next        = dp_rd_data;
        req.dp_rd_node = v;
        state_next     = S_QDB;
      end

      // order the pair so that u is the deeper node
      S_QDB: begin
        cmp_lhs = lcal_pkg::CMP_W'(du);
        cmp_rhs = lcal_pkg::CMP_W'(dp_rd_data);
        if (!cmp_ge) begin
          u_next  = v;
          v_next  = u;
          du_next = dp_rd_data;
          dv_next = du;
        end else begin
          dv_next = dp_rd_data;
        end
        k_next     = LAST_LVL;
        state_next = S_LCMP;
      end

      // lift u while it stays at least 2^k deeper than v
      S_LCMP: begin
        cmp_lhs = lcal_pkg::CMP_W'(du);
        cmp_rhs = lcal_pkg::CMP_W'(dv);
        cmp_add = 1'b1;
        if (cmp_ge) begin
          req.jt_rd_lvl  = k;
          req.jt_rd_node = u;
          state_next     = S_LJU;
        end else if (k == '0) begin
          k_next     = LAST_LVL;
          state_next = S_PRU;
        end else begin
          k_next = k - KW'(1);
        end
      end

      S_LJU: begin
        u_next         = jt_rd_data;
        req.dp_rd_node = jt_rd_data;
        state_next     = S_LDU;
      end

      S_LDU: begin
        du_next = dp_rd_data;
        if (k == '0) begin
          k_next     = LAST_LVL;
          state_next = S_PRU;
        end else begin
          k_next     = k - KW'(1);
          state_next = S_LCMP;
        end
      end

      // raise both nodes together while their ancestors differ
      S_PRU: begin
        req.jt_rd_lvl  = k;
        req.jt_rd_node = u;
        state_next     = S_PRV;
      end

      S_PRV: begin
        pu_next        = jt_rd_data;
        req.jt_rd_lvl  = k;
        req.jt_rd_node = v;
        state_next     = S_PCMP;
      end

      S_PCMP: begin
        cmp_lhs = lcal_pkg::CMP_W'(pu);
        cmp_rhs = lcal_pkg::CMP_W'(jt_rd_data);
        if (!cmp_eq) begin
          u_next = pu;
          v_next = jt_rd_data;
        end
        if (k == '0) begin
          state_next = S_FCHK;
        end else begin
          k_next     = k - KW'(1);
          state_next = S_PRU;
        end
      end

      // distinct children of the answer step up once
      S_FCHK: begin
        cmp_lhs = lcal_pkg::CMP_W'(u);
        cmp_rhs = lcal_pkg::CMP_W'(v);
        if (cmp_eq) begin
          done_next            = 1'b1;
          result_next.ancestor = u;
          result_next.status   = lcal_pkg::STATUS_OK;
          state_next           = S_IDLE;
        end else begin
          req.jt_rd_lvl  = '0;
          req.jt_rd_node = u;
          state_next     = S_FRD;
        end
      end

      S_FRD: begin
        done_next            = 1'b1;
        result_next.ancestor = jt_rd_data;
        result_next.status   = lcal_pkg::STATUS_OK;
        state_next           = S_IDLE;
      end

      // build: first hop of entry i arrives, fetch the second hop
      S_BX: begin
        req.jt_rd_lvl  = k - KW'(1);
        req.jt_rd_node = jt_rd_data;
        state_next     = S_BY;
      end

      // build: write entry i of level k and start the next entry
      S_BY: begin
        req.jt_we      = 1'b1;
        req.jt_wr_lvl  = k;
        req.jt_wr_node = i;
        req.jt_wr_data = jt_rd_data;
        if ({1'b0, i} == (n_eff - CW'(1))) begin
          if (k == LAST_LVL) begin
            done_next            = 1'b1;
            result_next.ancestor = '0;
            result_next.status   = lcal_pkg::STATUS_OK;
            table_built_next     = 1'b1;
            state_next           = S_IDLE;
          end else begin
            k_next         = k + KW'(1);
            i_next         = '0;
            req.jt_rd_lvl  = k;
            req.jt_rd_node = '0;
            state_next     = S_BX;
          end
        end else begin
          i_next         = i + NDW'(1);
          req.jt_rd_lvl  = k - KW'(1);
          req.jt_rd_node = i + NDW'(1);
          state_next     = S_BX;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      table_built <= 1'b0;
      node_count  <= lcal_pkg::COUNT_RESET;
      k           <= '0;
    end else begin
      state       <= state_next;
      done        <= done_next;
      table_built <= table_built_next;
      k           <= k_next;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i      <= i_next;
    u      <= u_next;
    v      <= v_next;
    pu     <= pu_next;
    du     <= du_next;
    dv     <= dv_next;
    result <= result_next;
  end

  `LCAL_ASSERT_IMP(a_jt_write_phase, clk, rst, req.jt_we, (state == S_BY) || ((state == S_IDLE) && start))
  `LCAL_ASSERT_IMP(a_dp_write_idle, clk, rst, req.dp_we, (state == S_IDLE) && start)
  `LCAL_ASSERT_IMP(a_no_build_status, clk, rst, done && (result.status == lcal_pkg::STATUS_NO_BUILD), !table_built)
  `LCAL_ASSERT_NXT(a_accept_answered, clk, rst, start && !busy, done || busy)
  `LCAL_ASSERT_IMP(a_level_range, clk, rst, state != S_IDLE, k <= LAST_LVL)

endmodule

/* sv/lowest_common_ancestor_lifting.sv */
// Lowest common ancestor by binary lifting: top level.
// Load, unknown-kind and rejected items: result one cycle after the transfer, next item
// taken in the following cycle. Query: the jump-table memory has a single read port, so the
// pair is read one node at a time (two reads per level when raising the pair).
// Build: two jump-table reads per entry. Results cannot stall.
// Synchronous reset clears the sequencer, the built flag and node_count (to 1024); memories keep data.
`timescale 1ns / 1ps

module lowest_common_ancestor_lifting #(
  parameter int NODES  = lcal_pkg::NODES_DEF,
  parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lcal_pkg::cmd_t               cmd,
  output logic                         busy,
  output logic                         done,
  output lcal_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic [lcal_pkg::COUNT_W-1:0] cfg_data
);

  lcal_pkg::mem_req_t                req;
  logic [lcal_pkg::NODE_W-1:0]       jt_rd_data;
  logic [lcal_pkg::DEPTH_W-1:0]      dp_rd_data;

  // sequencer with shared compare unit
  lcal_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .req        (req),
    .jt_rd_data (jt_rd_data),
    .dp_rd_data (dp_rd_data)
  );

  // jump table and depth memories
  lcal_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_store (
    .clk        (clk),
    .req        (req),
    .jt_rd_data (jt_rd_data),
    .dp_rd_data (dp_rd_data)
  );

endmodule
